// ===== rtl/erp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Euler point rotator: widths, CORDIC constants, lane and
// stage types, and the fixed-point helpers. No dependencies.
package erp_pkg;

  localparam int COORD_BITS     = 16;
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int PIVOT_BITS     = 16;
  localparam int OUT_BITS       = 18;
  localparam int CFG_IDX_BITS   = 2;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_FRAC  = 30;
  localparam int CW           = 34;
  localparam int SHIFT_BITS   = 5;
  localparam int TRIG_SHIFT   = CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam int TW           = TRIG_FRAC_BITS + 4;
  localparam int EW           = TW + 1;
  localparam int DW           = COORD_BITS + 2;
  localparam int AW           = EW + DW + 3;

  localparam logic signed [CW-1:0] CORDIC_START = CW'(652032874);
  localparam logic signed [PIVOT_BITS-1:0] PIVOT_RESET = PIVOT_BITS'(100);
  localparam logic signed [AW-1:0] OUT_MAX = AW'(131071);
  localparam logic signed [AW-1:0] OUT_MIN = -AW'(131072);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PIVOT_X = 2'd0,
    REG_PIVOT_Y = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic                 flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } lane_t;

  typedef struct packed {
    logic                 valid;
    lane_t [2:0]          lane;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } stage_t;

  function automatic logic signed [CW-1:0] atan_step(input logic [SHIFT_BITS-1:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:  r = CW'(536870912);
      5'd1:  r = CW'(316933406);
      5'd2:  r = CW'(167458907);
      5'd3:  r = CW'(85004756);
      5'd4:  r = CW'(42667331);
      5'd5:  r = CW'(21354465);
      5'd6:  r = CW'(10679838);
      5'd7:  r = CW'(5340245);
      5'd8:  r = CW'(2670163);
      5'd9:  r = CW'(1335087);
      5'd10: r = CW'(667544);
      5'd11: r = CW'(333772);
      5'd12: r = CW'(166886);
      5'd13: r = CW'(83443);
      5'd14: r = CW'(41722);
      5'd15: r = CW'(20861);
      5'd16: r = CW'(10430);
      5'd17: r = CW'(5215);
      5'd18: r = CW'(2608);
      5'd19: r = CW'(1304);
      5'd20: r = CW'(652);
      5'd21: r = CW'(326);
      5'd22: r = CW'(163);
      5'd23: r = CW'(81);
      5'd24: r = CW'(41);
      5'd25: r = CW'(20);
      5'd26: r = CW'(10);
      5'd27: r = CW'(5);
      5'd28: r = CW'(3);
      5'd29: r = CW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic lane_t fold_angle(input logic [ANGLE_BITS-1:0] ang);
    logic [31:0] a;
    lane_t       l;
    a = {ang, {(32-ANGLE_BITS){1'b0}}};
    l.flip = a[31] ^ a[30];
    if (l.flip) a[31] = ~a[31];
    l.x = CORDIC_START;
    l.y = '0;
    l.z = CW'(signed'(a));
    return l;
  endfunction

  function automatic logic signed [TW-1:0] round_trig(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = v + (CW'(1) <<< (TRIG_SHIFT - 1));
    return TW'(t >>> TRIG_SHIFT);
  endfunction

  function automatic logic signed [TW-1:0] mulq(input logic signed [TW-1:0] a,
                                               input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = a * b + ((2*TW)'(1) <<< (TRIG_FRAC_BITS - 1));
    return TW'(p >>> TRIG_FRAC_BITS);
  endfunction

endpackage

// ===== rtl/erp_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces for the Euler point rotator: point in, rotated point out.
// Depends on erp_pkg.
interface erp_in_if import erp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;
  logic [ANGLE_BITS-1:0]        angle_about_x;
  logic [ANGLE_BITS-1:0]        angle_about_y;
  logic [ANGLE_BITS-1:0]        angle_about_z;
  modport source (output valid, px, py, pz, angle_about_x, angle_about_y, angle_about_z,
                  input ready);
  modport sink (input valid, px, py, pz, angle_about_x, angle_about_y, angle_about_z,
                output ready);
endinterface

interface erp_out_if import erp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] rx;
  logic signed [OUT_BITS-1:0] ry;
  logic signed [OUT_BITS-1:0] rz;
  modport source (output valid, rx, ry, rz, input ready);
  modport sink (input valid, rx, ry, rz, output ready);
endinterface

// ===== rtl/erp_cell.sv =====
`timescale 1ns / 1ps
// One CORDIC rotation step for three angle lanes, carrying the point along.
// Depends on erp_pkg.
module erp_cell import erp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [SHIFT_BITS-1:0] step,
  input  stage_t                d,
  output stage_t                q
);

  stage_t q_next;
  logic signed [CW-1:0] atan;
  logic signed [CW-1:0] xs [3];
  logic signed [CW-1:0] ys [3];

  always_comb begin
    atan = atan_step(step);
    q_next = d;
    for (int k = 0; k < 3; k++) begin
      xs[k] = d.lane[k].x >>> step;
      ys[k] = d.lane[k].y >>> step;
      if (!d.lane[k].z[CW-1]) begin
        q_next.lane[k].x = d.lane[k].x - ys[k];
        q_next.lane[k].y = d.lane[k].y + xs[k];
        q_next.lane[k].z = d.lane[k].z - atan;
      end else begin
        q_next.lane[k].x = d.lane[k].x + ys[k];
        q_next.lane[k].y = d.lane[k].y - xs[k];
        q_next.lane[k].z = d.lane[k].z + atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) q.valid <= 1'b0;
    else if (en) q <= q_next;
  end

endmodule

// ===== rtl/erp_matrix.sv =====
`timescale 1ns / 1ps
// Builds the Rz*Ry*Rx matrix from the CORDIC outputs and applies it to the
// point, then rounds, adds the pivot and saturates. Depends on erp_pkg.
module erp_matrix import erp_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  stage_t                       d,
  input  logic signed [PIVOT_BITS-1:0] pivot_x,
  input  logic signed [PIVOT_BITS-1:0] pivot_y,
  output logic                         valid,
  output logic signed [OUT_BITS-1:0]   rx,
  output logic signed [OUT_BITS-1:0]   ry,
  output logic signed [OUT_BITS-1:0]   rz
);

  logic [4:0] v;
  logic signed [DW-1:0] c1 [3];
  logic signed [DW-1:0] c2 [3];
  logic signed [DW-1:0] c3 [3];
  logic signed [TW-1:0] cs [3];
  logic signed [TW-1:0] sn [3];
  logic signed [TW-1:0] czsy, szsy, czcy, szcy, szcx, szsx, czcx, czsx, cysx, cycx, sy;
  logic signed [TW-1:0] sx2, cx2;
  logic signed [EW-1:0] m [9];
  logic signed [AW-1:0] p [9];
  logic signed [AW-1:0] acc [3];
  logic signed [AW-1:0] res [3];
  logic signed [OUT_BITS-1:0] sat [3];
  logic signed [CW-1:0] vc [3];
  logic signed [CW-1:0] vs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vc[k] = d.lane[k].flip ? -d.lane[k].x : d.lane[k].x;
      vs[k] = d.lane[k].flip ? -d.lane[k].y : d.lane[k].y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (en) v <= {v[3:0], d.valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1[0] <= d.dx; c1[1] <= d.dy; c1[2] <= d.dz;
      for (int k = 0; k < 3; k++) begin
        cs[k] <= round_trig(vc[k]);
        sn[k] <= round_trig(vs[k]);
        c2[k] <= c1[k];
        c3[k] <= c2[k];
      end
      czsy <= mulq(cs[2], sn[1]);
      szsy <= mulq(sn[2], sn[1]);
      czcy <= mulq(cs[2], cs[1]);
      szcy <= mulq(sn[2], cs[1]);
      szcx <= mulq(sn[2], cs[0]);
      szsx <= mulq(sn[2], sn[0]);
      czcx <= mulq(cs[2], cs[0]);
      czsx <= mulq(cs[2], sn[0]);
      cysx <= mulq(cs[1], sn[0]);
      cycx <= mulq(cs[1], cs[0]);
      sy   <= sn[1];
      sx2  <= sn[0];
      cx2  <= cs[0];
      m[0] <= EW'(czcy);
      m[1] <= EW'(mulq(czsy, sx2)) - EW'(szcx);
      m[2] <= EW'(mulq(czsy, cx2)) + EW'(szsx);
      m[3] <= EW'(szcy);
      m[4] <= EW'(mulq(szsy, sx2)) + EW'(czcx);
      m[5] <= EW'(mulq(szsy, cx2)) - EW'(czsx);
      m[6] <= -EW'(sy);
      m[7] <= EW'(cysx);
      m[8] <= EW'(cycx);
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          p[3*r+k] <= AW'(m[3*r+k]) * AW'(c3[k]);
      for (int r = 0; r < 3; r++) sat[r] <= OUT_BITS'(res[r]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = p[3*r] + p[3*r+1] + p[3*r+2] + (AW'(1) <<< (TRIG_FRAC_BITS - 1));
      res[r] = acc[r] >>> TRIG_FRAC_BITS;
    end
    res[0] = res[0] + AW'(pivot_x);
    res[1] = res[1] + AW'(pivot_y);
    for (int r = 0; r < 3; r++) begin
      if (res[r] > OUT_MAX) res[r] = OUT_MAX;
      if (res[r] < OUT_MIN) res[r] = OUT_MIN;
    end
  end

  assign valid = v[4];
  assign rx = sat[0];
  assign ry = sat[1];
  assign rz = sat[2];

endmodule

// ===== rtl/euler_point_rotator.sv =====
`timescale 1ns / 1ps
// Euler point rotator top level: input folding, the CORDIC cell chain and
// the matrix unit. Depends on erp_pkg, erp_if, erp_cell and erp_matrix.
//
// Usage:
//   pin  carries one point (px, py, pz) with its three binary angles.
//   pout carries the rotated point (rx, ry, rz), one per input transaction.
//   cfg_we/cfg_index/cfg_data write pivot_x (index 0) or pivot_y (index 1);
//   other indexes are ignored. Write only while the block is empty.
// Pipeline:
//   30 CORDIC cells, each one rotation step on all three angles, then five
//   matrix stages. One point is accepted every cycle while pout is not
//   stalled.
// Reset:
//   rst clears all valid bits and sets both pivots to 100.
// Stall:
//   When pout is stalled with a result waiting, the whole chain holds and
//   pin.ready drops; it rises again the cycle the result is taken.
module euler_point_rotator import erp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  erp_in_if.sink                  pin,
  erp_out_if.source               pout,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PIVOT_BITS-1:0]   cfg_data
);

  logic signed [PIVOT_BITS-1:0] pivot_x;
  logic signed [PIVOT_BITS-1:0] pivot_y;
  logic   en;
  stage_t head;
  stage_t chain [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_x <= PIVOT_RESET;
      pivot_y <= PIVOT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIVOT_X: pivot_x <= signed'(cfg_data);
        REG_PIVOT_Y: pivot_y <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  assign en = !pout.valid || pout.ready;
  assign pin.ready = en;

  always_comb begin
    head.valid   = pin.valid;
    head.dx      = DW'(pin.px) - DW'(pivot_x);
    head.dy      = DW'(pin.py) - DW'(pivot_y);
    head.dz      = DW'(pin.pz);
    head.lane[0] = fold_angle(pin.angle_about_x);
    head.lane[1] = fold_angle(pin.angle_about_y);
    head.lane[2] = fold_angle(pin.angle_about_z);
  end

  assign chain[0] = head;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    erp_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .step (SHIFT_BITS'(i)),
      .d    (chain[i]),
      .q    (chain[i+1])
    );
  end

  erp_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .d       (chain[CORDIC_STEPS]),
    .pivot_x (pivot_x),
    .pivot_y (pivot_y),
    .valid   (pout.valid),
    .rx      (pout.rx),
    .ry      (pout.ry),
    .rz      (pout.rz)
  );

endmodule

// ===== rtl/erp_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the Euler point rotator, bound to the top level.
// Depends on erp_pkg.
module erp_checker import erp_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [OUT_BITS-1:0] rx
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output slot");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rx))
    else $error("stalled result changed");

endmodule

bind euler_point_rotator erp_checker u_erp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pin.ready),
  .out_valid (pout.valid),
  .out_ready (pout.ready),
  .rx        (pout.rx)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for euler_point_rotator: drives points with their Euler angles, predicts
// each rotated point with a CORDIC and fixed-point matrix model, and checks rx/ry/rz.
// Depends on erp_pkg, erp_if and the rotator RTL.
module tb;
  import erp_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  CYCLE_LIMIT  = 300000;
  localparam int  RANDOM_POINTS = 1100;
  localparam longint OUT_HI = 131071;
  localparam longint OUT_LO = -131072;
  localparam longint CORDIC_X0 = 652032874;
  localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  typedef struct {
    logic signed [COORD_BITS-1:0] px, py, pz;
    logic [ANGLE_BITS-1:0]        ax, ay, az;
  } point_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] rx, ry, rz;
  } rotated_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [PIVOT_BITS-1:0]   cfg_data = '0;

  erp_in_if  pin_if ();
  erp_out_if pout_if ();

  euler_point_rotator dut (
    .clk(clk), .rst(rst), .pin(pin_if), .pout(pout_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rotated_t rotated_q[$];
  longint   pivot_x = 100;
  longint   pivot_y = 100;
  int       mismatches = 0;
  int       cycles = 0;
  bit       quiet = 1'b0;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    pin_if.valid = 1'b0;
    pin_if.px = '0; pin_if.py = '0; pin_if.pz = '0;
    pin_if.angle_about_x = '0; pin_if.angle_about_y = '0; pin_if.angle_about_z = '0;
    pout_if.ready = 1'b0;
  end

  always @(negedge clk) begin
    pout_if.ready = quiet || ($urandom_range(99) >= 21);
  end

  function automatic longint mulq_ref(input longint a, input longint b);
    return (a * b + 8192) >>> TRIG_FRAC_BITS;
  endfunction

  function automatic void cordic_trig(input logic [ANGLE_BITS-1:0] ang,
                                      output longint c, output longint s);
    logic [31:0] a;
    bit          flip;
    longint      x, y, z, xs, ys;
    a = {ang, 16'b0};
    flip = a[31] ^ a[30];
    if (flip) a[31] = ~a[31];
    x = CORDIC_X0;
    y = 0;
    z = longint'(signed'(a));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_TURNS[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_TURNS[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = (x + (64'sd1 <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
    s = (y + (64'sd1 <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] rotate_row(
      input longint m0, m1, m2, v0, v1, v2, add);
    longint r;
    r = ((m0 * v0 + m1 * v1 + m2 * v2 + 8192) >>> TRIG_FRAC_BITS) + add;
    if (r > OUT_HI) r = OUT_HI;
    if (r < OUT_LO) r = OUT_LO;
    return OUT_BITS'(r);
  endfunction

  function automatic rotated_t rotate_point(input point_t p);
    longint dx, dy, dz, cx, sx, cy, sy, cz, sz, czsy, szsy;
    rotated_t r;
    dx = longint'(p.px) - pivot_x;
    dy = longint'(p.py) - pivot_y;
    dz = longint'(p.pz);
    cordic_trig(p.ax, cx, sx);
    cordic_trig(p.ay, cy, sy);
    cordic_trig(p.az, cz, sz);
    czsy = mulq_ref(cz, sy);
    szsy = mulq_ref(sz, sy);
    r.rx = rotate_row(mulq_ref(cz, cy), mulq_ref(czsy, sx) - mulq_ref(sz, cx),
                      mulq_ref(czsy, cx) + mulq_ref(sz, sx), dx, dy, dz, pivot_x);
    r.ry = rotate_row(mulq_ref(sz, cy), mulq_ref(szsy, sx) + mulq_ref(cz, cx),
                      mulq_ref(szsy, cx) - mulq_ref(cz, sx), dx, dy, dz, pivot_y);
    r.rz = rotate_row(-sy, mulq_ref(cy, sx), mulq_ref(cy, cx), dx, dy, dz, 0);
    return r;
  endfunction

  always @(posedge clk) begin
    rotated_t e;
    if (!rst && pout_if.valid && pout_if.ready) begin
      if (rotated_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result rx=%0d ry=%0d rz=%0d",
                   pout_if.rx, pout_if.ry, pout_if.rz);
      end else begin
        e = rotated_q.pop_front();
        if (pout_if.rx !== e.rx || pout_if.ry !== e.ry || pout_if.rz !== e.rz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d got %0d %0d %0d",
                     e.rx, e.ry, e.rz, pout_if.rx, pout_if.ry, pout_if.rz);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_point(input point_t p);
    rotated_t e;
    e = rotate_point(p);
    while (!quiet && $urandom_range(99) < 21) begin
      pin_if.valid = 1'b0;
      @(negedge clk);
    end
    pin_if.valid = 1'b1;
    pin_if.px = p.px; pin_if.py = p.py; pin_if.pz = p.pz;
    pin_if.angle_about_x = p.ax; pin_if.angle_about_y = p.ay; pin_if.angle_about_z = p.az;
    do @(posedge clk); while (!pin_if.ready);
    rotated_q.push_back(e);
    @(negedge clk);
  endtask

  task automatic drain();
    pin_if.valid = 1'b0;
    while (rotated_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_pivot(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [PIVOT_BITS-1:0] val);
    drain();
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_PIVOT_X) pivot_x = longint'(signed'(val));
    else if (idx == REG_PIVOT_Y) pivot_y = longint'(signed'(val));
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(200)) - 16'd100;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'($urandom_range(3)) << 14;
      1: return (16'($urandom_range(3)) << 14) + 16'($urandom_range(4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic point_t random_point();
    point_t p;
    p.px = pick_coord(); p.py = pick_coord(); p.pz = pick_coord();
    p.ax = pick_angle(); p.ay = pick_angle(); p.az = pick_angle();
    return p;
  endfunction

  task automatic test_directed();
    logic [15:0] angs [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h2000};
    point_t p;
    foreach (angs[i]) begin
      p = '{16'sh7fff, 16'sh8000, 16'sh7fff, angs[i], angs[(i+1)%6], angs[(i+2)%6]};
      send_point(p);
      p = '{16'sh8000, 16'sh7fff, 16'sh8000, angs[(i+3)%6], angs[i], angs[(i+4)%6]};
      send_point(p);
    end
    send_point('{16'sd100, 16'sd100, 16'sd0, 16'h0000, 16'h0000, 16'h0000});
    send_point('{16'sd0, 16'sd0, 16'sd0, 16'h2000, 16'h6000, 16'ha000});
    send_point('{16'sd1, -16'sd1, 16'sd1, 16'h0001, 16'h7fff, 16'h8001});
  endtask

  task automatic test_pivot_extremes();
    write_pivot(REG_PIVOT_X, 16'h8000);
    write_pivot(REG_PIVOT_Y, 16'h7fff);
    repeat (40) send_point(random_point());
    write_pivot(REG_PIVOT_X, 16'h7fff);
    write_pivot(REG_PIVOT_Y, 16'h8000);
    repeat (40) send_point(random_point());
    write_pivot(REG_PIVOT_X, 16'h0000);
    write_pivot(REG_PIVOT_Y, 16'hffff);
    repeat (40) send_point(random_point());
  endtask

  task automatic test_spare_index();
    write_pivot(REG_SPARE_LO, 16'h1234);
    write_pivot(REG_SPARE_HI, 16'h8000);
    repeat (20) send_point(random_point());
  endtask

  task automatic test_random();
    for (int i = 0; i < RANDOM_POINTS; i++) begin
      if (i % 300 == 0) begin
        write_pivot(REG_PIVOT_X, 16'($urandom));
        write_pivot(REG_PIVOT_Y, 16'($urandom));
      end
      quiet = (i >= 500 && i < 700);
      send_point(random_point());
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_pivot_extremes();
    test_spare_index();
    test_random();
    drain();
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/erp_pkg.sv
rtl/erp_if.sv
rtl/erp_cell.sv
rtl/erp_matrix.sv
rtl/euler_point_rotator.sv
rtl/erp_checker.sv
sim/tb.sv
